// ===== src/kgsr_pkg.sv =====
// ----------------------------------------------------------------------------
// kgsr_pkg
// Shared types for the k-group stream reverser: controller states and the
// read request that the sequencer hands to the buffer and output pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package kgsr_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned GSIZE_W = 7;

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_t;

  // flags that ride with one buffer read down to the output register
  typedef struct packed {
    logic issue;
    logic run_last;
    logic list_end;
  } rd_req_t;

endpackage

`default_nettype wire

// ===== src/kgsr_emit.sv =====
// ----------------------------------------------------------------------------
// kgsr_emit
// Group buffer memory with a registered read, followed by the
// output register. The read stage and the output stage advance together.
// ----------------------------------------------------------------------------
`default_nettype none

module kgsr_emit #(
  parameter int unsigned MAX_GROUP = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAX_GROUP)-1:0]  wr_addr,
  input  wire logic [kgsr_pkg::VALUE_W-1:0]  wr_data,
  input  wire kgsr_pkg::rd_req_t             rd_req,
  input  wire logic [$clog2(MAX_GROUP)-1:0]  rd_addr,
  output logic                               advance,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [kgsr_pkg::VALUE_W-1:0]       m_tdata,  // out_value
  output logic                               m_tlast,  // out_list_end
  output logic                               m_tuser   // run_last
);

  logic [kgsr_pkg::VALUE_W-1:0] mem [MAX_GROUP];
  logic [kgsr_pkg::VALUE_W-1:0] rdata;
  logic                         s1_valid;
  logic                         s1_run_last;
  logic                         s1_list_end;

  assign advance = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (advance && rd_req.issue) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      s1_valid <= rd_req.issue;
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_run_last <= rd_req.run_last;
      s1_list_end <= rd_req.list_end;
      m_tdata     <= rdata;
      m_tuser     <= s1_run_last;
      m_tlast     <= s1_list_end;
    end
  end

endmodule

`default_nettype wire

// ===== src/k_group_stream_reverser.sv =====
// emission: the request that completes a group or ends a list starts the reads;
//   results pass the read and output registers, one per cycle under m_tready
// throughput: one request per cycle while a group fills; a group of n results
//   holds s_tready low while the single buffer read port drains it
// reset: rst synchronous, clears fill count, state and valids; group_size = 4;
//   buffer contents are not cleared
// ----------------------------------------------------------------------------
// k_group_stream_reverser
// Buffers list elements and emits each full group in reverse order; a short
// remainder at the end of a list is emitted in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module k_group_stream_reverser #(
  parameter int unsigned MAX_GROUP = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [kgsr_pkg::GSIZE_W-1:0]  cfg_wdata,  // group_size
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [kgsr_pkg::VALUE_W-1:0]  s_tdata,    // elem_value
  input  wire logic                          s_tlast,    // list_end
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [kgsr_pkg::VALUE_W-1:0]       m_tdata,    // out_value
  output logic                               m_tlast,    // out_list_end
  output logic                               m_tuser     // run_last
);

  localparam int unsigned AW = $clog2(MAX_GROUP);
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);
  localparam int unsigned XW = (CW > kgsr_pkg::GSIZE_W) ? CW : kgsr_pkg::GSIZE_W;

  kgsr_pkg::state_t  state, state_next;
  kgsr_pkg::rd_req_t rd_req;

  logic [kgsr_pkg::GSIZE_W-1:0] group_size;
  logic [CW-1:0]                fill;
  logic [CW-1:0]                fill_new;
  logic [CW-1:0]                size_eff;
  logic [XW-1:0]                gs_x;
  logic [AW-1:0]                rd_addr;
  logic [CW-1:0]                rd_left;
  logic                         rd_down;
  logic                         emit_end;
  logic                         accept;
  logic                         group_full;
  logic                         last_read;
  logic                         advance;

  // zero counts as one, anything above the buffer depth saturates
  always_comb begin
    gs_x = XW'(group_size);
    if (gs_x == '0) begin
      size_eff = CW'(1);
    end else if (gs_x > XW'(MAX_GROUP)) begin
      size_eff = CW'(MAX_GROUP);
    end else begin
      size_eff = gs_x[CW-1:0];
    end
  end

  assign accept     = s_tvalid && s_tready;
  assign fill_new   = fill + CW'(1);
  assign group_full = fill_new >= size_eff;
  assign last_read  = rd_left == CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= kgsr_pkg::GSIZE_W'(4);
    end else if (cfg_we) begin
      group_size <= cfg_wdata;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kgsr_pkg::ST_FILL: begin
        if (accept && (group_full || s_tlast)) begin
          state_next = kgsr_pkg::ST_EMIT;
        end
      end
      kgsr_pkg::ST_EMIT: begin
        if (advance && last_read) begin
          state_next = kgsr_pkg::ST_FILL;
        end
      end
      default: state_next = kgsr_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    rd_req.issue    = 1'b0;
    rd_req.run_last = last_read;
    rd_req.list_end = last_read && emit_end;
    case (state)
      kgsr_pkg::ST_FILL: s_tready     = 1'b1;
      kgsr_pkg::ST_EMIT: rd_req.issue = 1'b1;
      default: begin
        s_tready     = 1'b0;
        rd_req.issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kgsr_pkg::ST_FILL;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill <= (group_full || s_tlast) ? '0 : fill_new;
      end
    end
  end

  // read sequencer: full group walks down from the newest entry, a remainder
  // walks up from entry zero
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_left  <= fill_new;
      rd_down  <= group_full;
      rd_addr  <= group_full ? fill[AW-1:0] : '0;
      emit_end <= s_tlast;
    end else if (state == kgsr_pkg::ST_EMIT && advance) begin
      rd_left <= rd_left - CW'(1);
      rd_addr <= rd_down ? rd_addr - AW'(1) : rd_addr + AW'(1);
    end
  end

  kgsr_emit #(
    .MAX_GROUP (MAX_GROUP)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_addr  (fill[AW-1:0]),
    .wr_data  (s_tdata),
    .rd_req   (rd_req),
    .rd_addr  (rd_addr),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill < CW'(MAX_GROUP))
    else $error("fill count reached buffer depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == kgsr_pkg::ST_EMIT) |-> (rd_left != '0))
    else $error("emitting with no reads left");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (state == kgsr_pkg::ST_EMIT))
    else $error("list end request did not start an emission");

  a_end_on_run_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("list end flagged on a result that does not close its run");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives lists of elements into k_group_stream_reverser and checks every
// output element against a predictor kept in step with each accepted
// request. Covers short lists, full groups, group size changes and random
// lists under source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GROUP_MAX = 64;

  typedef struct packed {
    logic [kgsr_pkg::VALUE_W-1:0] value;
    logic                         list_end;
    logic                         run_last;
  } elem_rec_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  logic [kgsr_pkg::GSIZE_W-1:0] cfg_wdata;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [kgsr_pkg::VALUE_W-1:0] s_tdata;   // elem_value
  logic                         s_tlast;   // list_end
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [kgsr_pkg::VALUE_W-1:0] m_tdata;   // out_value
  logic                         m_tlast;   // out_list_end
  logic                         m_tuser;   // run_last

  // predictor state
  logic [kgsr_pkg::VALUE_W-1:0] held_elems [GROUP_MAX];
  int                           held_count;
  int                           cur_group_size;
  elem_rec_t                    awaited_elems [$];

  int mismatch_count = 0;
  int src_idle_pct   = 0;
  int snk_stall_pct  = 0;

  k_group_stream_reverser #(.MAX_GROUP(GROUP_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #6 clk = ~clk;

  // sink back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // buffer one element, queue whatever group or remainder it releases
  function automatic void queue_released_elems(logic [31:0] v, logic lst);
    int        eff;
    int        n0;
    elem_rec_t rec;
    eff = cur_group_size;
    if (eff == 0) eff = 1;
    if (eff > GROUP_MAX) eff = GROUP_MAX;
    if (held_count < GROUP_MAX) begin
      held_elems[held_count] = v;
      held_count++;
    end
    n0 = awaited_elems.size();
    if (held_count >= eff) begin
      for (int i = held_count - 1; i >= 0; i--)
        awaited_elems.push_back('{value: held_elems[i], list_end: 1'b0, run_last: 1'b0});
      held_count = 0;
    end else if (lst) begin
      for (int i = 0; i < held_count; i++)
        awaited_elems.push_back('{value: held_elems[i], list_end: 1'b0, run_last: 1'b0});
      held_count = 0;
    end
    if (awaited_elems.size() > n0) begin
      rec = awaited_elems.pop_back();
      rec.run_last = 1'b1;
      rec.list_end = lst;
      awaited_elems.push_back(rec);
    end
  endfunction

  // output checker
  always @(posedge clk) begin
    elem_rec_t exp_rec;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_elems.size() == 0) begin
        $display("%0t: unexpected result: value %h list_end %b run_last %b",
                 $time, m_tdata, m_tlast, m_tuser);
        mismatch_count++;
      end else begin
        exp_rec = awaited_elems.pop_front();
        if (exp_rec.value !== m_tdata || exp_rec.list_end !== m_tlast ||
            exp_rec.run_last !== m_tuser) begin
          $display({"%0t: mismatch: expected value %h list_end %b run_last %b,",
                    " got value %h list_end %b run_last %b"},
                   $time, exp_rec.value, exp_rec.list_end, exp_rec.run_last,
                   m_tdata, m_tlast, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_elem(input logic [31:0] v, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    queue_released_elems(v, lst);
  endtask

  // drain all outstanding results, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (awaited_elems.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_group_size(input int g);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= g[kgsr_pkg::GSIZE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_group_size = g;
  endtask

  // lists shorter than the reset group size pass through in order
  task automatic test_short_lists();
    send_elem(32'h7fff_ffff, 1'b1);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'h0000_0000, 1'b1);
    send_elem(32'hffff_ffff, 1'b0);
    send_elem(32'h0000_0001, 1'b0);
    send_elem(32'h5555_5555, 1'b1);
  endtask

  // full group ending a list, and a group followed by a remainder
  task automatic test_full_groups();
    send_elem(32'haaaa_aaaa, 1'b0);
    send_elem(32'h0000_0011, 1'b0);
    send_elem(32'h0000_0022, 1'b0);
    send_elem(32'h8000_0001, 1'b1);
    for (int k = 1; k <= 6; k++)
      send_elem(32'h100 + k, k == 6);
  endtask

  // zero acts as one, oversize saturates
  task automatic test_size_extremes();
    set_group_size(0);
    send_elem(32'h1234_5678, 1'b0);
    send_elem(32'hfedc_ba98, 1'b1);
    set_group_size(127);
    send_elem(32'h0000_00aa, 1'b0);
    send_elem(32'h0000_00bb, 1'b1);
  endtask

  // lowering the size below the fill count releases the whole buffer reversed
  task automatic test_size_lowered();
    set_group_size(8);
    for (int k = 0; k < 5; k++)
      send_elem(32'h200 + k, 1'b0);
    set_group_size(2);
    send_elem(32'h0000_0205, 1'b1);
  endtask

  task automatic test_random_lists();
    int          sizes [8] = '{3, 1, 64, 0, 5, 127, 2, 4};
    int          grp;
    int          len;
    int          sent;
    logic [31:0] v;
    logic        lst;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
        default: begin src_idle_pct = 10; snk_stall_pct = 10; end
      endcase
      set_group_size(sizes[p]);
      grp = (sizes[p] > GROUP_MAX) ? GROUP_MAX : sizes[p];
      sent = 0;
      while (sent < 40) begin
        len = $urandom_range(1, grp + grp / 2 + 2);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(7))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'hffff_ffff;
            3: v = 32'h0000_0000;
            default: v = $urandom;
          endcase
          lst = (k == len - 1);
          // occasional stray or missing end of list
          if ($urandom_range(19) == 0) lst = ~lst;
          send_elem(v, lst);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    held_count     = 0;
    cur_group_size = 4;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_lists();
    test_full_groups();
    test_size_extremes();
    test_size_lowered();
    test_random_lists();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
